// ===== hdl/sitda_pkg.sv =====
package sitda_pkg;

  // Default width of the signed input value.
  localparam int VALUE_WIDTH_DEFAULT = 32;

  // Decimal radix and the width of one BCD digit.
  localparam int Radix = 10;
  localparam int DIGIT_BITS = 4;

  // Digits of 5 or more are corrected by 3 before each doubling.
  localparam logic [DIGIT_BITS-1:0] DABBLE_LIMIT = 4'd5;
  localparam logic [DIGIT_BITS-1:0] DABBLE_ADJUST = 4'd3;

  // ASCII codes of the characters that the block emits.
  localparam logic [7:0] CHAR_ZERO = 8'h30;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;

  // Number of decimal digits in the largest magnitude, 2^(width-1).
  // This runs at elaboration only.
  function automatic int dec_digits(input int width);
    longint unsigned v;
    int n;
    v = 64'd1 << (width - 1);
    n = 0;
    for (int i = 0; i < 20; i++) begin
      if (v != 0) begin
        v = v / Radix;
        n = n + 1;
      end
    end
    return n;
  endfunction

endpackage

// ===== hdl/sitda_dabble.sv =====
// One step of the shared double-dabble unit: four magnitude bits, most
// significant first, are shifted into the BCD digit register.
module sitda_dabble
  import sitda_pkg::*;
#(
  parameter int NUM_DIGITS = 10
) (
  input  logic [NUM_DIGITS*DIGIT_BITS-1:0] bcd,
  input  logic [DIGIT_BITS-1:0]            bits,
  output logic [NUM_DIGITS*DIGIT_BITS-1:0] bcd_next
);

  localparam int BCD_W = NUM_DIGITS * DIGIT_BITS;

  // Four dependent add-3-and-shift passes; the digits of one pass are independent.
  always_comb begin
    logic [BCD_W-1:0] b;
    b = bcd;
    for (int k = DIGIT_BITS - 1; k >= 0; k--) begin
      for (int d = 0; d < NUM_DIGITS; d++) begin
        if (b[d*DIGIT_BITS +: DIGIT_BITS] >= DABBLE_LIMIT) begin
          b[d*DIGIT_BITS +: DIGIT_BITS] = b[d*DIGIT_BITS +: DIGIT_BITS] + DABBLE_ADJUST;
        end
      end
      b = {b[BCD_W-2:0], bits[k]};
    end
    bcd_next = b;
  end

endmodule

// ===== hdl/signed_int_to_decimal_ascii.sv =====
// Channel   Ports                     Handshake
// -------   -----------------------   -------------------------------------
// request   value                     taken when start is high, busy is low
// result    character, last           shown for one cycle while valid is high
//
// A request is converted by the shared double-dabble unit, four bits a
// cycle, the leading digit is then found, and the digits go out one per
// cycle. A minus sign is registered in the leading-digit state, ahead of the
// digits, so it does not delay them. At 32 bits a result has 1 to 10 digits.
// Busy falls with the last character, and the next request can be taken at
// the edge that ends that character. The receiver cannot stall, so results
// go out at once. Reset (synchronous, active high) returns the sequencer to
// idle.
module signed_int_to_decimal_ascii
  import sitda_pkg::*;
#(
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic signed [VALUE_WIDTH-1:0] value,
  output logic                          busy,
  output logic                          valid,
  output logic [7:0]                    character,
  output logic                          last
);

  localparam int NUM_DIGITS = dec_digits(VALUE_WIDTH);
  localparam int NIBBLES = (VALUE_WIDTH + DIGIT_BITS - 1) / DIGIT_BITS;
  localparam int PAD_W = NIBBLES * DIGIT_BITS;
  localparam int BCD_W = NUM_DIGITS * DIGIT_BITS;
  localparam int CNT_W = $clog2(NIBBLES + 1);
  localparam int POS_W = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;
  localparam int DCNT_W = $clog2(NUM_DIGITS + 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_CONV = 2'd1;
  localparam logic [1:0] S_LEAD = 2'd2;
  localparam logic [1:0] S_EMIT = 2'd3;

  logic [1:0]             state;
  logic [PAD_W-1:0]       magnitude;
  logic [BCD_W-1:0]       digit_store;
  logic [BCD_W-1:0]       digit_store_next;
  logic [CNT_W-1:0]       nibble_count;
  logic [DCNT_W-1:0]      lead_count;
  logic [POS_W-1:0]       pos;
  logic                   is_negative;
  logic [VALUE_WIDTH-1:0] raw;
  logic [VALUE_WIDTH-1:0] abs_value;

  assign busy = (state != S_IDLE);

  // Unsigned magnitude; the most negative value comes out exact.
  assign raw = value;
  assign abs_value = raw[VALUE_WIDTH-1] ? (~raw + 1'b1) : raw;

  // Shared conversion unit, fed the top nibble of the magnitude.
  sitda_dabble #(
    .NUM_DIGITS(NUM_DIGITS)
  ) u_dabble (
    .bcd     (digit_store),
    .bits    (magnitude[PAD_W-1 -: DIGIT_BITS]),
    .bcd_next(digit_store_next)
  );

  // Count of significant digits; zero still gives one digit.
  always_comb begin
    lead_count = DCNT_W'(1);
    for (int i = 0; i < NUM_DIGITS; i++) begin
      if (digit_store[i*DIGIT_BITS +: DIGIT_BITS] != '0) begin
        lead_count = DCNT_W'(i + 1);
      end
    end
  end

  // Sequencer and datapath registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      valid <= 1'b0;
      is_negative <= 1'b0;
    end else begin
      valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            is_negative <= raw[VALUE_WIDTH-1];
            magnitude <= PAD_W'(abs_value);
            digit_store <= '0;
            nibble_count <= CNT_W'(NIBBLES);
            state <= S_CONV;
          end
        end
        S_CONV: begin
          digit_store <= digit_store_next;
          magnitude <= magnitude << DIGIT_BITS;
          nibble_count <= nibble_count - 1'b1;
          if (nibble_count == CNT_W'(1)) begin
            state <= S_LEAD;
          end
        end
        S_LEAD: begin
          pos <= POS_W'(lead_count - 1'b1);
          if (is_negative) begin
            valid <= 1'b1;
            character <= CHAR_MINUS;
            last <= 1'b0;
          end
          state <= S_EMIT;
        end
        S_EMIT: begin
          valid <= 1'b1;
          character <= CHAR_ZERO + 8'(digit_store[pos*DIGIT_BITS +: DIGIT_BITS]);
          last <= (pos == '0);
          if (pos == '0) begin
            state <= S_IDLE;
          end else begin
            pos <= pos - 1'b1;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
